// ===== hdl/ffsa_pkg.sv =====
// Shared types, constants and helpers for the first-fit segment allocator.
package ffsa_pkg;

  localparam int SLOT_COUNT = 512;
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int LINK_W = SLOT_W + 1;
  localparam int STEP_W = SLOT_W + 1;
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 25;
  localparam int STAT_W = 3;

  localparam logic [LINK_W-1:0] NIL = {LINK_W{1'b1}};
  localparam logic [SIZE_W-1:0] HEAP_BYTES_RST = SIZE_W'(524288);

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_FREE = 2'd1;
  localparam logic [1:0] KIND_RESV = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_FIT = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_SPARE = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_ZERO_SIZE = 3'd4;

  localparam logic REG_HEAP_BASE = 1'b0;
  localparam logic REG_HEAP_BYTES = 1'b1;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic cmd;
    logic [SIZE_W-1:0] request_bytes;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    logic [STAT_W-1:0] status;
  } rsp_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic [LINK_W-1:0] nxt;
    logic [LINK_W-1:0] prv;
  } seg_t;

  typedef struct packed {
    logic en;
    logic [SLOT_W-1:0] addr;
    seg_t data;
  } tbl_wr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] sum;
    logic ge;
    logic eq;
  } alu_res_t;

  localparam seg_t EMPTY_SEG = '{kind: KIND_EMPTY, start: '0, size: '0, nxt: NIL, prv: NIL};

  function automatic logic link_ok(input logic [LINK_W-1:0] link);
    return link < LINK_W'(SLOT_COUNT);
  endfunction

endpackage

// ===== hdl/ffsa_alu.sv =====
// Shared adder/subtractor and comparator used by the sequencer steps that add or compare.
module ffsa_alu (
  input  logic op,
  input  logic [ffsa_pkg::ADDR_W-1:0] a,
  input  logic [ffsa_pkg::ADDR_W-1:0] b,
  output ffsa_pkg::alu_res_t res
);
  import ffsa_pkg::*;

  logic [ADDR_W:0] full;

  // Subtraction is a + ~b + 1; its carry out is the unsigned a >= b flag.
  assign full = {1'b0, a} + {1'b0, (op == ALU_SUB) ? ~b : b} + {{ADDR_W{1'b0}}, op == ALU_SUB};
  assign res.sum = full[ADDR_W-1:0];
  assign res.ge = full[ADDR_W];
  assign res.eq = (a == b);

endmodule

// ===== hdl/ffsa_table.sv =====
// Segment table memory: one write port and one registered read port.
module ffsa_table (
  input  logic clk,
  input  ffsa_pkg::tbl_wr_t wr,
  input  logic [ffsa_pkg::SLOT_W-1:0] rd_addr,
  output ffsa_pkg::seg_t rd_data
);
  import ffsa_pkg::*;

  seg_t mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/first_fit_segment_allocator_top.sv =====
// Top level of the first-fit segment allocator: sequencer, config and handshake.
// A zero-size allocate goes straight to the result state after acceptance. Otherwise each
// visited segment takes a table read, then a compare, each probed slot of the spare
// search takes a read and a check, and then comes the split or merge tail.
// The block handles one request at a time.
// Reset and every heap_bytes write start a clearing pass over the whole table.
module first_fit_segment_allocator_top (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  ffsa_pkg::req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output ffsa_pkg::rsp_t rsp,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [31:0] cfg_data
);
  import ffsa_pkg::*;

  // Sequencer state codes.
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_WREQ = 5'd1;
  localparam logic [4:0] S_WCHK = 5'd2;
  localparam logic [4:0] S_SREQ = 5'd3;
  localparam logic [4:0] S_SCHK = 5'd4;
  localparam logic [4:0] S_NEW = 5'd5;
  localparam logic [4:0] S_PVRD = 5'd6;
  localparam logic [4:0] S_PVWR = 5'd7;
  localparam logic [4:0] S_CADD = 5'd8;
  localparam logic [4:0] S_CWR = 5'd9;
  localparam logic [4:0] S_FPRD = 5'd10;
  localparam logic [4:0] S_FPCHK = 5'd11;
  localparam logic [4:0] S_FPPRD = 5'd12;
  localparam logic [4:0] S_FPPWR = 5'd13;
  localparam logic [4:0] S_FNRD = 5'd14;
  localparam logic [4:0] S_FNCHK = 5'd15;
  localparam logic [4:0] S_FNNRD = 5'd16;
  localparam logic [4:0] S_FNNWR = 5'd17;
  localparam logic [4:0] S_FCWR = 5'd18;
  localparam logic [4:0] S_FIN = 5'd19;

  localparam logic [SLOT_W-1:0] SLOT_ONE = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

  logic [4:0] state;

  // Configuration and the values latched for the clearing pass.
  logic [ADDR_W-1:0] heap_base;
  logic [ADDR_W-1:0] init_base;
  logic [SIZE_W-1:0] init_bytes;
  logic clearing;
  logic [SLOT_W-1:0] clr_ptr;

  // List head and the rotating spare-slot search pointer.
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] sp;
  logic [SLOT_W-1:0] sp_first;
  logic [SLOT_W-1:0] sp_inc;

  // The request being worked on.
  logic cmd;
  logic [SIZE_W-1:0] req_bytes;
  logic [ADDR_W-1:0] free_addr;

  // Walk cursor, step count, the matched segment and the new slot of a split.
  logic [LINK_W-1:0] cur;
  logic [STEP_W-1:0] steps;
  seg_t cseg;
  logic [SLOT_W-1:0] nw;
  logic [ADDR_W-1:0] tmp_start;

  // Result under construction.
  logic [ADDR_W-1:0] res_addr;
  logic [STAT_W-1:0] res_status;

  // Table and shared arithmetic unit.
  tbl_wr_t tbl_wr;
  logic [SLOT_W-1:0] rd_addr;
  seg_t rd_data;
  logic alu_op;
  logic [ADDR_W-1:0] alu_a;
  logic [ADDR_W-1:0] alu_b;
  alu_res_t alu;

  logic fit;
  logic hit;

  ffsa_table u_table (
    .clk(clk),
    .wr(tbl_wr),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  ffsa_alu u_alu (
    .op(alu_op),
    .a(alu_a),
    .b(alu_b),
    .res(alu)
  );

  // Requests are taken only by an idle sequencer with the table cleared.
  assign req_stall = (state != S_IDLE) || clearing;

  // A free segment fits when its size is at least the request (compare in S_WCHK).
  assign fit = (rd_data.kind == KIND_FREE) && alu.ge;
  assign hit = (rd_data.kind == KIND_RESV) && alu.eq;

  assign sp_inc = (sp == SLOT_LAST) ? '0 : sp + SLOT_W'(1);

  // Operand selection, table read address and the single write per cycle.
  always_comb begin
    alu_op = ALU_SUB;
    alu_a = '0;
    alu_b = '0;
    rd_addr = cur[SLOT_W-1:0];
    tbl_wr = '0;
    case (state)
      S_WCHK: begin
        if (cmd == CMD_ALLOC) begin
          alu_a = ADDR_W'(rd_data.size);
          alu_b = ADDR_W'(req_bytes);
          if (fit && alu.eq) begin
            tbl_wr.en = 1'b1;
            tbl_wr.addr = cur[SLOT_W-1:0];
            tbl_wr.data = rd_data;
            tbl_wr.data.kind = KIND_RESV;
          end
        end else begin
          alu_a = rd_data.start;
          alu_b = free_addr;
        end
      end
      S_SREQ: rd_addr = sp;
      S_NEW: begin
        tbl_wr.en = 1'b1;
        tbl_wr.addr = nw;
        tbl_wr.data = '{kind: KIND_RESV, start: cseg.start, size: req_bytes,
                        nxt: cur, prv: cseg.prv};
      end
      S_PVRD: rd_addr = cseg.prv[SLOT_W-1:0];
      S_PVWR: begin
        tbl_wr.en = 1'b1;
        tbl_wr.addr = cseg.prv[SLOT_W-1:0];
        tbl_wr.data = rd_data;
        tbl_wr.data.nxt = {1'b0, nw};
      end
      S_CADD: begin
        alu_op = ALU_ADD;
        alu_a = cseg.start;
        alu_b = ADDR_W'(req_bytes);
      end
      S_CWR: begin
        alu_a = ADDR_W'(cseg.size);
        alu_b = ADDR_W'(req_bytes);
        tbl_wr.en = 1'b1;
        tbl_wr.addr = cur[SLOT_W-1:0];
        tbl_wr.data = '{kind: KIND_FREE, start: tmp_start, size: alu.sum[SIZE_W-1:0],
                        nxt: cseg.nxt, prv: {1'b0, nw}};
      end
      S_FPRD: rd_addr = cseg.prv[SLOT_W-1:0];
      S_FPCHK: begin
        alu_op = ALU_ADD;
        alu_a = ADDR_W'(cseg.size);
        alu_b = ADDR_W'(rd_data.size);
        if (rd_data.kind == KIND_FREE) begin
          tbl_wr.en = 1'b1;
          tbl_wr.addr = cseg.prv[SLOT_W-1:0];
          tbl_wr.data = EMPTY_SEG;
        end
      end
      S_FPPRD: rd_addr = cseg.prv[SLOT_W-1:0];
      S_FPPWR: begin
        tbl_wr.en = 1'b1;
        tbl_wr.addr = cseg.prv[SLOT_W-1:0];
        tbl_wr.data = rd_data;
        tbl_wr.data.nxt = cur;
      end
      S_FNRD: rd_addr = cseg.nxt[SLOT_W-1:0];
      S_FNCHK: begin
        alu_op = ALU_ADD;
        alu_a = ADDR_W'(cseg.size);
        alu_b = ADDR_W'(rd_data.size);
        if (rd_data.kind == KIND_FREE) begin
          tbl_wr.en = 1'b1;
          tbl_wr.addr = cseg.nxt[SLOT_W-1:0];
          tbl_wr.data = EMPTY_SEG;
        end
      end
      S_FNNRD: rd_addr = cseg.nxt[SLOT_W-1:0];
      S_FNNWR: begin
        tbl_wr.en = 1'b1;
        tbl_wr.addr = cseg.nxt[SLOT_W-1:0];
        tbl_wr.data = rd_data;
        tbl_wr.data.prv = cur;
      end
      S_FCWR: begin
        tbl_wr.en = 1'b1;
        tbl_wr.addr = cur[SLOT_W-1:0];
        tbl_wr.data = cseg;
        tbl_wr.data.kind = KIND_FREE;
      end
      default: ;
    endcase
    // The clearing pass owns the write port; slot one becomes the whole heap.
    if (clearing) begin
      tbl_wr.en = 1'b1;
      tbl_wr.addr = clr_ptr;
      if (clr_ptr == SLOT_ONE) begin
        tbl_wr.data = '{kind: KIND_FREE, start: init_base, size: init_bytes,
                        nxt: NIL, prv: NIL};
      end else begin
        tbl_wr.data = EMPTY_SEG;
      end
    end
  end

  // Sequencer, result register and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
      heap_base <= '0;
      init_base <= '0;
      init_bytes <= HEAP_BYTES_RST;
      clearing <= 1'b1;
      clr_ptr <= '0;
      head <= SLOT_ONE;
      sp <= SLOT_ONE;
    end else begin
      // The result beat leaves unless a new one is loaded in the same cycle.
      if (rsp_valid && !rsp_stall && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      if (clearing && !(cfg_we && cfg_index == REG_HEAP_BYTES)) begin
        clr_ptr <= clr_ptr + SLOT_W'(1);
        if (clr_ptr == SLOT_LAST) begin
          clearing <= 1'b0;
        end
      end
      case (state)
        S_IDLE: begin
          if (req_valid && !req_stall) begin
            cmd <= req.cmd;
            req_bytes <= req.request_bytes;
            free_addr <= req.free_address;
            res_addr <= '0;
            cur <= {1'b0, head};
            steps <= '0;
            if (req.cmd == CMD_ALLOC && req.request_bytes == '0) begin
              res_status <= ST_ZERO_SIZE;
              state <= S_FIN;
            end else begin
              state <= S_WREQ;
            end
          end
        end
        S_WREQ: begin
          if (!link_ok(cur) || steps == STEP_W'(SLOT_COUNT)) begin
            res_status <= (cmd == CMD_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
            state <= S_FIN;
          end else begin
            state <= S_WCHK;
          end
        end
        S_WCHK: begin
          cseg <= rd_data;
          if (cmd == CMD_ALLOC && fit) begin
            if (alu.eq) begin
              res_addr <= rd_data.start;
              res_status <= ST_OK;
              state <= S_FIN;
            end else begin
              sp_first <= sp;
              state <= S_SREQ;
            end
          end else if (cmd == CMD_FREE && hit) begin
            state <= S_FPRD;
          end else begin
            cur <= rd_data.nxt;
            steps <= steps + STEP_W'(1);
            state <= S_WREQ;
          end
        end
        S_SREQ: state <= S_SCHK;
        S_SCHK: begin
          if (rd_data.kind == KIND_EMPTY) begin
            nw <= sp;
            state <= S_NEW;
          end else begin
            sp <= sp_inc;
            if (sp_inc == sp_first) begin
              res_status <= ST_NO_SPARE;
              state <= S_FIN;
            end else begin
              state <= S_SREQ;
            end
          end
        end
        S_NEW: begin
          if (link_ok(cseg.prv)) begin
            state <= S_PVRD;
          end else begin
            head <= nw;
            state <= S_CADD;
          end
        end
        S_PVRD: state <= S_PVWR;
        S_PVWR: state <= S_CADD;
        S_CADD: begin
          tmp_start <= alu.sum;
          state <= S_CWR;
        end
        S_CWR: begin
          res_addr <= cseg.start;
          res_status <= ST_OK;
          state <= S_FIN;
        end
        S_FPRD: state <= link_ok(cseg.prv) ? S_FPCHK : S_FNRD;
        S_FPCHK: begin
          state <= S_FNRD;
          if (rd_data.kind == KIND_FREE) begin
            cseg.start <= rd_data.start;
            cseg.size <= alu.sum[SIZE_W-1:0];
            cseg.prv <= rd_data.prv;
            if (link_ok(rd_data.prv)) begin
              state <= S_FPPRD;
            end else begin
              head <= cur[SLOT_W-1:0];
            end
          end
        end
        S_FPPRD: state <= S_FPPWR;
        S_FPPWR: state <= S_FNRD;
        S_FNRD: state <= link_ok(cseg.nxt) ? S_FNCHK : S_FCWR;
        S_FNCHK: begin
          state <= S_FCWR;
          if (rd_data.kind == KIND_FREE) begin
            cseg.size <= alu.sum[SIZE_W-1:0];
            cseg.nxt <= rd_data.nxt;
            if (link_ok(rd_data.nxt)) begin
              state <= S_FNNRD;
            end
          end
        end
        S_FNNRD: state <= S_FNNWR;
        S_FNNWR: state <= S_FCWR;
        S_FCWR: begin
          res_status <= ST_OK;
          state <= S_FIN;
        end
        S_FIN: begin
          // Hand the result to the output register once it is free.
          if (!rsp_valid || !rsp_stall) begin
            rsp.block_address <= res_addr;
            rsp.status <= res_status;
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // A heap_bytes write rebuilds the table from the current heap_base.
      if (cfg_we) begin
        if (cfg_index == REG_HEAP_BASE) begin
          heap_base <= cfg_data;
        end else begin
          init_base <= heap_base;
          init_bytes <= cfg_data[SIZE_W-1:0];
          clearing <= 1'b1;
          clr_ptr <= '0;
          head <= SLOT_ONE;
          sp <= SLOT_ONE;
        end
      end
    end
  end

  // An accepted request always leaves the idle state on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state != S_IDLE))
    else $error("accepted request did not start the sequencer");

  // Only a successful allocate reports a nonzero block address.
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |-> (rsp.block_address == '0))
    else $error("failed request reported a block address");

  // Outside the clearing pass, a table write happens only while a request is being worked on.
  a_wr_slot: assert property (@(posedge clk) disable iff (rst)
    (tbl_wr.en && !clearing) |-> (state != S_IDLE && state != S_FIN))
    else $error("table written outside an active request");

  // The clearing pass ends after writing the last slot unless a config write intervenes.
  a_clear_end: assert property (@(posedge clk) disable iff (rst)
    (clearing && clr_ptr == SLOT_LAST && !cfg_we) |=> !clearing)
    else $error("clearing pass did not end after the last slot");

endmodule

// ===== dv/ffsa_scoreboard.sv =====
// Scoreboard class: tracks the segment table and predicts each allocator response.
`timescale 1ns / 100ps
package ffsa_tb_pkg;
  import ffsa_pkg::*;

  class alloc_scoreboard;
    logic [1:0]        kind [SLOT_COUNT];
    logic [ADDR_W-1:0] start [SLOT_COUNT];
    logic [SIZE_W-1:0] size [SLOT_COUNT];
    int                nxt [SLOT_COUNT];
    int                prv [SLOT_COUNT];
    int                head;
    int                spare_ptr;
    logic [ADDR_W-1:0] base_reg;
    logic [SIZE_W-1:0] bytes_reg;
    rsp_t              pending[$];
    int                errors;
    int                checked;
    int                ok_allocs;
    int                ok_frees;
    int                fails[5];
    logic [ADDR_W-1:0] live[$];

    function new();
      base_reg = '0;
      bytes_reg = HEAP_BYTES_RST;
      errors = 0;
      checked = 0;
      ok_allocs = 0;
      ok_frees = 0;
      foreach (fails[i]) fails[i] = 0;
      rebuild();
    endfunction

    function void wipe(int s);
      kind[s] = KIND_EMPTY;
      start[s] = '0;
      size[s] = '0;
      nxt[s] = -1;
      prv[s] = -1;
    endfunction

    function void rebuild();
      for (int i = 0; i < SLOT_COUNT; i++) wipe(i);
      kind[1] = KIND_FREE;
      start[1] = base_reg;
      size[1] = bytes_reg;
      head = 1;
      spare_ptr = 1;
      live.delete();
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      if (idx == REG_HEAP_BASE) base_reg = data;
      else begin
        bytes_reg = data[SIZE_W-1:0];
        rebuild();
      end
    endfunction

    function int spare_slot();
      int first;
      first = spare_ptr;
      do begin
        if (kind[spare_ptr] == KIND_EMPTY) return spare_ptr;
        spare_ptr = (spare_ptr >= SLOT_COUNT - 1) ? 0 : spare_ptr + 1;
      end while (spare_ptr != first);
      return -1;
    endfunction

    function rsp_t do_alloc(logic [SIZE_W-1:0] req);
      rsp_t r;
      int cur, nw, pv;
      r.block_address = '0;
      r.status = ST_NO_FIT;
      if (req == 0) begin
        r.status = ST_ZERO_SIZE;
        return r;
      end
      cur = head;
      for (int steps = 0; steps < SLOT_COUNT && cur >= 0; steps++) begin
        if (kind[cur] == KIND_FREE && size[cur] >= req) begin
          if (size[cur] == req) begin
            kind[cur] = KIND_RESV;
            r.block_address = start[cur];
            r.status = ST_OK;
            return r;
          end
          nw = spare_slot();
          if (nw < 0) begin
            r.status = ST_NO_SPARE;
            return r;
          end
          pv = prv[cur];
          kind[nw] = KIND_RESV;
          start[nw] = start[cur];
          size[nw] = req;
          nxt[nw] = cur;
          prv[nw] = pv;
          if (pv >= 0) nxt[pv] = nw;
          else head = nw;
          prv[cur] = nw;
          start[cur] = start[cur] + ADDR_W'(req);
          size[cur] = size[cur] - req;
          r.block_address = start[nw];
          r.status = ST_OK;
          return r;
        end
        cur = nxt[cur];
      end
      return r;
    endfunction

    function rsp_t do_free(logic [ADDR_W-1:0] addr);
      rsp_t r;
      int cur, pv, nx, pp, nn;
      r.block_address = '0;
      r.status = ST_NOT_FOUND;
      cur = head;
      for (int steps = 0; steps < SLOT_COUNT && cur >= 0; steps++) begin
        if (kind[cur] == KIND_RESV && start[cur] == addr) begin
          pv = prv[cur];
          nx = nxt[cur];
          kind[cur] = KIND_FREE;
          if (pv >= 0 && kind[pv] == KIND_FREE) begin
            pp = prv[pv];
            start[cur] = start[pv];
            size[cur] = size[cur] + size[pv];
            prv[cur] = pp;
            if (pp >= 0) nxt[pp] = cur;
            else head = cur;
            wipe(pv);
          end
          if (nx >= 0 && kind[nx] == KIND_FREE) begin
            nn = nxt[nx];
            size[cur] = size[cur] + size[nx];
            nxt[cur] = nn;
            if (nn >= 0) prv[nn] = cur;
            wipe(nx);
          end
          r.status = ST_OK;
          return r;
        end
        cur = nxt[cur];
      end
      return r;
    endfunction

    // Called for every request beat the block accepts.
    function void note_request(req_t q);
      rsp_t r;
      if (q.cmd == CMD_ALLOC) begin
        r = do_alloc(q.request_bytes);
        if (r.status == ST_OK) begin
          live.push_back(r.block_address);
          ok_allocs++;
        end
      end else begin
        r = do_free(q.free_address);
        if (r.status == ST_OK) begin
          ok_frees++;
          foreach (live[i]) if (live[i] == q.free_address) begin
            live.delete(i);
            break;
          end
        end
      end
      fails[r.status]++;
      pending.push_back(r);
    endfunction

    // Prints one line for a failed comparison and counts it.
    task report_mismatch(string what);
      $display("ERROR: %s", what);
      errors++;
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      checked++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("response beat with nothing expected: addr %h status %0d",
                                  got.block_address, got.status));
        return;
      end
      want = pending.pop_front();
      if (got.block_address !== want.block_address) begin
        report_mismatch($sformatf("block_address %h, expected %h", got.block_address,
                                  want.block_address));
      end
      if (got.status !== want.status) begin
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      end
    endtask
  endclass
endpackage

// ===== dv/tb.sv =====
// Testbench top: drives requests and config writes into the allocator and checks responses.
`timescale 1ns / 100ps
module tb;
  import ffsa_pkg::*;
  import ffsa_tb_pkg::*;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;

  first_fit_segment_allocator_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  alloc_scoreboard sb;

  // Idle percentages for the two sides: send_request reads send_idle_pct, the receiver reads recv_stall_pct.
  int send_idle_pct;
  int recv_stall_pct;
  // When nonzero, the receiver holds stall high and counts hold_cycles down to zero.
  int hold_cycles;
  int quiet_cycles;
  int mismatches_seen;

  // This limit is far beyond the worst request, a clearing pass and a long receiver hold,
  // taken several times over.
  localparam int QUIET_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4 * SLOT_COUNT + 600;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side: samples the response at the edge, then decides the next stall.
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // The watchdog ends the run after a long stretch with no beat on either channel.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || rst) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offers one request beat, with a random gap first, and waits until it is taken.
  // Valid stays high after the beat until the next gap or the next pause drops it.
  task automatic send_request(req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= q;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_request(q);
  endtask

  // Waits for every expected response, then lets any in-flight work finish.
  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes only happen while the block is idle.
  task automatic write_reg(logic idx, logic [31:0] data);
    drain();
    cfg_index <= idx;
    cfg_data <= data;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    // The clearing pass stalls the request side, so no fixed wait is needed here.
  endtask

  function automatic req_t alloc_req(logic [SIZE_W-1:0] n);
    req_t q;
    q.cmd = CMD_ALLOC;
    q.request_bytes = n;
    q.free_address = $urandom();
    return q;
  endfunction

  function automatic req_t free_req(logic [ADDR_W-1:0] a);
    req_t q;
    q.cmd = CMD_FREE;
    q.request_bytes = SIZE_W'($urandom());
    q.free_address = a;
    return q;
  endfunction

  // Mostly well-formed traffic: allocations of small sizes and frees of live blocks,
  // with some bad frees, zero sizes and oversized requests mixed in.
  task automatic random_traffic(int count, int max_req);
    int pick;
    logic [ADDR_W-1:0] a;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_request(alloc_req(SIZE_W'($urandom_range(max_req, 1))));
      end else if (pick < 85 && sb.live.size() != 0) begin
        a = sb.live[$urandom_range(sb.live.size() - 1)];
        send_request(free_req(a));
      end else if (pick < 90) begin
        send_request(alloc_req(pick[0] ? '0 : SIZE_W'($urandom())));
      end else if (pick < 95) begin
        send_request(free_req($urandom()));
      end else begin
        a = sb.base_reg + ADDR_W'($urandom_range(max_req));
        send_request(free_req(a));
      end
    end
  endtask

  initial begin
    sb = new();
    mismatches_seen = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_index = REG_HEAP_BASE;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset heap: zero size, exact fit of the whole heap,
    // double free, no fit, oversize, free of a free segment, and merges on both sides.
    send_request(alloc_req('0));
    send_request(alloc_req(SIZE_W'(524288)));
    send_request(alloc_req(SIZE_W'(1)));
    send_request(free_req(32'h0));
    send_request(free_req(32'h0));
    send_request(alloc_req(SIZE_W'(24'hFFFFFF) + 1'b1));
    send_request(alloc_req(SIZE_W'(100)));
    send_request(alloc_req(SIZE_W'(200)));
    send_request(alloc_req(SIZE_W'(300)));
    send_request(free_req(32'd100));
    send_request(free_req(32'd0));
    send_request(free_req(32'd300));
    send_request(free_req(32'd600));
    send_request(free_req(32'hFFFF_FFFF));

    // Base near the top of the address space so that starts wrap, with a heap of 2^24 bytes.
    write_reg(REG_HEAP_BASE, 32'hFFFF_FF00);
    write_reg(REG_HEAP_BYTES, 32'h0100_0000);
    send_request(alloc_req(SIZE_W'(256)));
    send_request(alloc_req(SIZE_W'(512)));
    send_request(free_req(32'hFFFF_FF00));
    send_request(free_req(32'h0000_0000));
    send_request(alloc_req(SIZE_W'(32'h0100_0000)));

    // Zero heap: every allocate has no fit.
    write_reg(REG_HEAP_BYTES, 32'h0);
    send_request(alloc_req(SIZE_W'(1)));
    send_request(free_req(32'hFFFF_FF00));

    // Random phases over a range of settings and idle mixes. The slot table fills up
    // in the single-byte phase at the end, which reaches the no-spare-slot case.
    write_reg(REG_HEAP_BASE, $urandom());
    write_reg(REG_HEAP_BYTES, 32'd524288);
    random_traffic(200, 4096);

    send_idle_pct = 56;
    write_reg(REG_HEAP_BASE, 32'h0);
    write_reg(REG_HEAP_BYTES, 32'd1);
    random_traffic(40, 2);

    send_idle_pct = 0;
    recv_stall_pct = 56;
    write_reg(REG_HEAP_BASE, $urandom());
    write_reg(REG_HEAP_BYTES, 32'd4096);
    random_traffic(200, 128);

    // Long receiver hold while the sender keeps offering beats.
    recv_stall_pct = 0;
    hold_cycles = 3000;
    random_traffic(20, 64);
    // The sender now pauses until every expected response has come.
    req_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);

    send_idle_pct = 31;
    recv_stall_pct = 31;
    write_reg(REG_HEAP_BASE, 32'hFFFF_FFFF);
    write_reg(REG_HEAP_BYTES, 32'h0100_0000);
    random_traffic(150, 4096);

    // Small heap with single-byte requests drives the table to full.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(REG_HEAP_BYTES, 32'd2000);
    for (int i = 0; i < 530; i++) send_request(alloc_req(SIZE_W'(1)));
    random_traffic(30, 3);

    drain();
    mismatches_seen += sb.errors;
    $display("Checked %0d responses: %0d allocations and %0d frees succeeded.",
             sb.checked, sb.ok_allocs, sb.ok_frees);
    $display("Failures seen: no fit %0d, no spare %0d, not found %0d, zero size %0d.",
             sb.fails[ST_NO_FIT], sb.fails[ST_NO_SPARE], sb.fails[ST_NOT_FOUND],
             sb.fails[ST_ZERO_SIZE]);
    if (mismatches_seen == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
